/* rtl/core/bb3_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur stream
// Field widths, item structs, command and register codes, divide-by-nine.
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 4096;

	localparam int COL_W  = 11;   // out_col / column counters
	localparam int ROW_W  = 12;   // out_row / row counters
	localparam int WCFG_W = 12;   // image_width register
	localparam int HCFG_W = 13;   // image_height register
	localparam int CFG_W  = 13;   // widest register
	localparam int IDX_W  = 1;    // two registers
	localparam int SUM_W  = 12;   // nine 8-bit values
	localparam int PIX_W  = 24;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
	localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);
	localparam logic [WCFG_W-1:0] WIDTH_LIMIT  = WCFG_W'(MAX_WIDTH);
	localparam logic [HCFG_W-1:0] HEIGHT_LIMIT = HCFG_W'(MAX_HEIGHT);

	// floor(s/9) = (s * 7282) >> 16 for every s below 2^SUM_W / 1.78
	localparam int DIV9_RECIP = 7282;
	localparam int DIV9_SHIFT = 16;
	localparam int PROD_W     = SUM_W + 14;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0]       red_out;
		logic [7:0]       green_out;
		logic [7:0]       blue_out;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
		logic             frame_last;
	} out_item_t;

	// decoded item, handed from the accept stage to the window stage
	typedef struct packed {
		logic             pixel;
		logic             emit;
		logic             mean;
		logic             sel_mid;
		logic [COL_W-1:0] addr;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} dec_t;

	typedef struct packed {
		logic [SUM_W-1:0] r;
		logic [SUM_W-1:0] g;
		logic [SUM_W-1:0] b;
	} sums_t;

	function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] p;
		p = PROD_W'(s) * PROD_W'(DIV9_RECIP);
		return p[DIV9_SHIFT+7:DIV9_SHIFT];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/bb3_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_stream_if: valid/ready channels of the box blur stream
// Input channel carries one pixel or drain item, output channel one result.
// ----------------------------------------------------------------------------
interface bb3_in_if;
	import bb3_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface bb3_out_if;
	import bb3_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/bb3_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (old on collision).
// ----------------------------------------------------------------------------
module bb3_ram #(
	parameter  int WIDTH  = 24,
	parameter  int DEPTH  = 2048,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bb3_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ctrl: size registers, position counters and item decode
// Decides at accept time what an item does and advances the counters.
// ----------------------------------------------------------------------------
module bb3_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [bb3_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [bb3_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                       accept,
	input  wire logic                       cmd,
	output      logic                       enter,
	output      bb3_pkg::dec_t              dec
);
	import bb3_pkg::*;

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic              done_q;

	logic [WCFG_W-1:0] eff_w;
	logic [HCFG_W-1:0] eff_h;
	logic in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
	logic out_col_end, out_row_end, last;
	logic is_pixel, has_result;

	always_comb begin
		eff_w = width_q;
		if (width_q == '0) eff_w = WCFG_W'(1);
		else if (width_q > WIDTH_LIMIT) eff_w = WIDTH_LIMIT;
		eff_h = height_q;
		if (height_q == '0) eff_h = HCFG_W'(1);
		else if (height_q > HEIGHT_LIMIT) eff_h = HEIGHT_LIMIT;
	end

	assign in_col_wrap  = (WCFG_W'(in_col_q) + WCFG_W'(1)) >= eff_w;
	assign in_row_wrap  = (HCFG_W'(in_row_q) + HCFG_W'(1)) >= eff_h;
	assign out_col_wrap = (WCFG_W'(out_col_q) + WCFG_W'(1)) >= eff_w;
	assign out_row_wrap = (HCFG_W'(out_row_q) + HCFG_W'(1)) >= eff_h;
	assign out_col_end  = WCFG_W'(out_col_q) >= (eff_w - WCFG_W'(1));
	assign out_row_end  = HCFG_W'(out_row_q) >= (eff_h - HCFG_W'(1));
	assign last         = out_row_end && out_col_end;

	assign is_pixel   = (cmd == CMD_PIXEL);
	assign has_result = (in_row_q >= ROW_W'(2))
		|| ((in_row_q == ROW_W'(1)) && (in_col_q >= COL_W'(1)));

	always_comb begin
		dec.pixel   = is_pixel;
		dec.emit    = is_pixel ? has_result : 1'b1;
		dec.mean    = is_pixel && (in_row_q >= ROW_W'(2)) && (in_col_q >= COL_W'(2));
		dec.sel_mid = out_row_end;
		dec.addr    = is_pixel ? in_col_q : out_col_q;
		dec.row     = out_row_q;
		dec.col     = out_col_q;
		dec.last    = last;
		enter       = accept && (is_pixel ? !done_q : done_q);
	end

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WCFG_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HCFG_W-1:0];
				default:    ;
			endcase
		end
	end

	// counters and frame-done flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			done_q    <= 1'b0;
		end else if (enter) begin
			if (dec.emit) begin
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_wrap ? '0 : out_row_q + ROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			if (is_pixel) begin
				if (in_col_wrap) begin
					in_col_q <= '0;
					if (in_row_wrap) begin
						in_row_q <= '0;
					end else begin
						in_row_q <= in_row_q + ROW_W'(1);
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			// end of input frame wins over the last result of the flush
			if (is_pixel && in_col_wrap && in_row_wrap) begin
				done_q <= 1'b1;
			end else if (dec.emit && last) begin
				done_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/core/bb3_win.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_win: 3x3 window registers and channel sums
// Holds the two previous columns of three rows and sums the nine values.
// ----------------------------------------------------------------------------
module bb3_win (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire bb3_pkg::pix_t up,
	input  wire bb3_pkg::pix_t mid,
	input  wire bb3_pkg::pix_t pix,
	output      bb3_pkg::pix_t centre,
	output      bb3_pkg::sums_t sums
);
	import bb3_pkg::*;

	pix_t win_q [6];
	pix_t taps  [9];

	always_comb begin
		for (int k = 0; k < 6; k++) taps[k] = win_q[k];
		taps[6] = up;
		taps[7] = mid;
		taps[8] = pix;
		sums = '0;
		for (int k = 0; k < 9; k++) begin
			sums.r = sums.r + SUM_W'(taps[k][23:16]);
			sums.g = sums.g + SUM_W'(taps[k][15:8]);
			sums.b = sums.b + SUM_W'(taps[k][7:0]);
		end
	end

	assign centre = win_q[4];

	// advance window one column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 6; k++) win_q[k] <= '0;
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= up;
			win_q[4] <= mid;
			win_q[5] <= pix;
		end
	end
endmodule
`default_nettype wire

/* rtl/core/box_blur_3x3_stream.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_stream: 3x3 mean filter over a raster stream of RGB pixels
// Top level: accept/decode, line stores, window stage, divide and output.
// ----------------------------------------------------------------------------
// The block takes one item per clock (pixel or drain) while the result
// channel is not back-pressured and returns each pixel of the frame with
// every channel set to floor(sum of its 3x3 neighborhood/9); the first and
// last row and column pass through unchanged. Results trail the input by
// width+1 pixels; after the last pixel of a frame, send width+1 drain items
// (a whole frame for a one-row frame) to flush the rest. A drain before the
// frame is complete, and a pixel while the flush is pending, are dropped
// without a result. Throughput is one item per cycle when not stalled; the
// two line stores are MAX_WIDTH x 24 RAMs with one read and one write per
// cycle. An item passes through decode and RAM read, window and sums, and
// divide by nine into the output register. Back-pressure on the result
// channel stalls the pipeline and holds pixels.ready low once the three
// stages hold results. Write image_width and image_height only while the
// block is idle. The line stores are not cleared by reset; no start-up sweep.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [bb3_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bb3_pkg::CFG_W-1:0] cfg_data,
	bb3_in_if.sink                         pixels,
	bb3_out_if.source                      results
);
	import bb3_pkg::*;

	// accept stage
	logic accept, enter;
	dec_t dec;
	pix_t pix_new;

	// window stage
	logic valid_s1, byp_s1;
	dec_t dec_s1;
	pix_t pix_s1, fwd_up_s1, fwd_mid_s1;
	pix_t up_rd, mid_rd, up_eff, mid_eff, centre, val_s1_d;
	sums_t sums;

	// divide stage
	logic  valid_s2, mean_s2;
	sums_t sums_s2;
	pix_t  val_s2;
	logic [ROW_W-1:0] row_s2;
	logic [COL_W-1:0] col_s2;
	logic  last_s2;

	// output register
	logic      out_valid_q;
	out_item_t out_q;

	// handshake chain
	logic out_free, s2_free, s1_adv, s1_free, byp;

	assign out_free = !out_valid_q || results.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_adv   = valid_s1 && (s2_free || !dec_s1.emit);
	assign s1_free  = !valid_s1 || s1_adv;
	assign pixels.ready = s1_free;
	assign accept   = pixels.valid && pixels.ready;

	assign pix_new = {pixels.data.red_in, pixels.data.green_in, pixels.data.blue_in};

	bb3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.cmd       (pixels.data.cmd),
		.enter     (enter),
		.dec       (dec)
	);

	// line stores: upper holds the row two back, middle the row one back
	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (s1_adv && dec_s1.pixel),
		.waddr (dec_s1.addr),
		.wdata (mid_eff),
		.re    (enter),
		.raddr (dec.addr),
		.rdata (up_rd)
	);

	bb3_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (s1_adv && dec_s1.pixel),
		.waddr (dec_s1.addr),
		.wdata (pix_s1),
		.re    (enter),
		.raddr (dec.addr),
		.rdata (mid_rd)
	);

	// forward the column being written this cycle: the RAM returns old data
	assign byp = s1_adv && dec_s1.pixel && (dec_s1.addr == dec.addr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= enter;
		end
	end

	always_ff @(posedge clk) begin
		if (enter) begin
			dec_s1     <= dec;
			pix_s1     <= pix_new;
			byp_s1     <= byp;
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	assign up_eff  = byp_s1 ? fwd_up_s1 : up_rd;
	assign mid_eff = byp_s1 ? fwd_mid_s1 : mid_rd;

	bb3_win u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (s1_adv && dec_s1.pixel),
		.up     (up_eff),
		.mid    (mid_eff),
		.pix    (pix_s1),
		.centre (centre),
		.sums   (sums)
	);

	// drains flush the stored rows; border pixels take the window center
	always_comb begin
		if (!dec_s1.pixel) begin
			val_s1_d = dec_s1.sel_mid ? mid_eff : up_eff;
		end else begin
			val_s1_d = centre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_adv && dec_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_adv && dec_s1.emit) begin
			sums_s2 <= sums;
			val_s2  <= val_s1_d;
			mean_s2 <= dec_s1.mean;
			row_s2  <= dec_s1.row;
			col_s2  <= dec_s1.col;
			last_s2 <= dec_s1.last;
		end
	end

	// divide by nine, or pass the value through, and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_q.red_out    <= mean_s2 ? div9(sums_s2.r) : val_s2[23:16];
			out_q.green_out  <= mean_s2 ? div9(sums_s2.g) : val_s2[15:8];
			out_q.blue_out   <= mean_s2 ? div9(sums_s2.b) : val_s2[7:0];
			out_q.out_row    <= row_s2;
			out_q.out_col    <= col_s2;
			out_q.frame_last <= last_s2;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;
endmodule
`default_nettype wire
